FILE: src/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed-point constants for the HSV to RGB converter.
// No dependencies; every other file in src imports this package.
package hsv2rgb_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LVL_W     = FRAC_BITS + 1;
   localparam int CK_W      = FRAC_BITS + 6;
   localparam int XPROD_W   = CK_W + LVL_W;
   localparam int PCT_W     = 7;
   localparam int HUE_W     = 9;
   localparam int PROD_W    = 14;
   localparam int K_W       = 6;
   localparam int XV_W      = 14;
   localparam int XC_W      = 27;

   localparam int HUE_MAX  = 359;
   localparam int PCT_MAX  = 100;
   localparam int PCT_SQ   = 10000;
   localparam int SEXTANT  = 60;
   localparam int BYTE_MAX = 255;

   localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

   localparam logic [LVL_W-1:0] V_QUOT = LVL_W'(ONE / PCT_MAX);
   localparam logic [6:0]       V_REM  = 7'(ONE % PCT_MAX);
   localparam logic [LVL_W-1:0] C_QUOT = LVL_W'(ONE / PCT_SQ);
   localparam logic [13:0]      C_REM  = 14'(ONE % PCT_SQ);

   localparam int               V_SHIFT = XV_W;
   localparam logic [7:0]       V_RECIP = 8'((64'd1 << V_SHIFT) / PCT_MAX);
   localparam int               C_SHIFT = XC_W;
   localparam logic [13:0]      C_RECIP = 14'((64'd1 << C_SHIFT) / PCT_SQ);
   localparam logic [LVL_W-1:0] X_RECIP = LVL_W'((64'd1 << CK_W) / SEXTANT);

   typedef enum logic [2:0] {
      SECTOR_RED,
      SECTOR_YELLOW,
      SECTOR_GREEN,
      SECTOR_CYAN,
      SECTOR_BLUE,
      SECTOR_MAGENTA
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_deg;
      logic [PCT_W-1:0] sat_pct;
      logic [PCT_W-1:0] val_pct;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic [LVL_W-1:0] vf;
      logic [LVL_W-1:0] c;
      logic [K_W-1:0]   k;
      sector_type       sector;
   } front_type;

endpackage

FILE: src/hsv_to_rgb_converter_core.sv
`timescale 1ns / 1ps
// HSV to RGB converter top level: second-component, channel and byte stages.
// Depends on hsv2rgb_pkg and hsv2rgb_front.
//
//   channel   ports                      handshake
//   request   start, busy, req_data      taken when start is high and busy is low
//   response  rsp_strobe, rsp_data       valid for the one cycle rsp_strobe is high
//
// One transaction is taken every cycle; busy is always low.
// Each response is registered through the eight register stages of the
// constant-divider pipeline: a to d in hsv2rgb_front, then e, f, g and rsp here.
// Synchronous reset clears the stage valid bits and drops transactions in flight.
// The receiver cannot stall, so the pipeline never holds.
module hsv_to_rgb_converter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  hsv2rgb_pkg::req_type req_data,
   output logic                 rsp_strobe,
   output hsv2rgb_pkg::rsp_type rsp_data
);
   import hsv2rgb_pkg::*;

   typedef struct packed {
      logic [CK_W-1:0]  ck;
      logic [LVL_W-1:0] m;
      logic [LVL_W-1:0] c;
      sector_type       sector;
   } e_stage_type;

   typedef struct packed {
      logic [CK_W-1:0]  ck;
      logic [LVL_W-1:0] ex;
      logic [LVL_W-1:0] m;
      logic [LVL_W-1:0] c;
      sector_type       sector;
   } f_stage_type;

   typedef struct packed {
      logic [LVL_W-1:0] x;
      logic [LVL_W-1:0] m;
      logic [LVL_W-1:0] c;
      sector_type       sector;
   } g_stage_type;

   function automatic logic [7:0] to_byte(input logic [LVL_W-1:0] level);
      logic [LVL_W+7:0] scaled;
      logic [8:0]       whole;
      scaled = {level, 8'd0} - (LVL_W + 8)'(level);
      whole  = scaled[LVL_W+7:FRAC_BITS];
      return (whole > 9'(BYTE_MAX)) ? 8'(BYTE_MAX) : whole[7:0];
   endfunction

   front_type   front;
   logic        e_valid_ff, f_valid_ff, g_valid_ff, rsp_strobe_ff;
   e_stage_type e_ff, e_in;
   f_stage_type f_ff, f_in;
   g_stage_type g_ff, g_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [XPROD_W-1:0] x_prod;
   logic [CK_W-1:0]    x_rem;
   logic [LVL_W-1:0]   red_lvl, green_lvl, blue_lvl;

   assign busy = 1'b0;

   hsv2rgb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .out      (front)
   );

   always_comb begin
      e_in.ck     = CK_W'(front.c) * CK_W'(front.k);
      e_in.m      = front.vf - front.c;
      e_in.c      = front.c;
      e_in.sector = front.sector;
   end

   always_comb begin
      x_prod      = XPROD_W'(e_ff.ck) * XPROD_W'(X_RECIP);
      f_in.ck     = e_ff.ck;
      f_in.ex     = x_prod[CK_W+FRAC_BITS:CK_W];
      f_in.m      = e_ff.m;
      f_in.c      = e_ff.c;
      f_in.sector = e_ff.sector;
   end

   always_comb begin
      x_rem       = f_ff.ck - CK_W'(f_ff.ex) * CK_W'(SEXTANT);
      g_in.x      = f_ff.ex + LVL_W'(x_rem >= CK_W'(SEXTANT));
      g_in.m      = f_ff.m;
      g_in.c      = f_ff.c;
      g_in.sector = f_ff.sector;
   end

   always_comb begin
      unique case (g_ff.sector)
         SECTOR_RED: begin
            red_lvl = g_ff.c;  green_lvl = g_ff.x;  blue_lvl = '0;
         end
         SECTOR_YELLOW: begin
            red_lvl = g_ff.x;  green_lvl = g_ff.c;  blue_lvl = '0;
         end
         SECTOR_GREEN: begin
            red_lvl = '0;      green_lvl = g_ff.c;  blue_lvl = g_ff.x;
         end
         SECTOR_CYAN: begin
            red_lvl = '0;      green_lvl = g_ff.x;  blue_lvl = g_ff.c;
         end
         SECTOR_BLUE: begin
            red_lvl = g_ff.x;  green_lvl = '0;      blue_lvl = g_ff.c;
         end
         SECTOR_MAGENTA: begin
            red_lvl = g_ff.c;  green_lvl = '0;      blue_lvl = g_ff.x;
         end
         default: begin
            red_lvl = g_ff.c;  green_lvl = '0;      blue_lvl = g_ff.x;
         end
      endcase
      rsp_data_in.red   = to_byte(red_lvl + g_ff.m);
      rsp_data_in.green = to_byte(green_lvl + g_ff.m);
      rsp_data_in.blue  = to_byte(blue_lvl + g_ff.m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff    <= 1'b0;
         f_valid_ff    <= 1'b0;
         g_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         e_valid_ff    <= front.valid;
         f_valid_ff    <= e_valid_ff;
         g_valid_ff    <= f_valid_ff;
         rsp_strobe_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_ff        <= e_in;
      f_ff        <= f_in;
      g_ff        <= g_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Every accepted transaction produces exactly one response once it has passed the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##8 rsp_strobe)
      else $error("accepted transaction produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 8))
      else $error("response without a matching transaction");

   // Zero saturation gives a gray pixel; zero value gives black.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.sat_pct, 8) == '0) |->
         (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue))
      else $error("unsaturated pixel is not gray");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.val_pct, 8) == '0) |->
         (rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0))
      else $error("zero-value pixel is not black");

endmodule

FILE: src/hsv2rgb_front.sv
`timescale 1ns / 1ps
// Front pipeline: input clamping, hue sector, value level and chroma.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hsv2rgb_pkg::req_type   in_data,
   output hsv2rgb_pkg::front_type out
);
   import hsv2rgb_pkg::*;

   typedef struct packed {
      logic [PCT_W-1:0]  v;
      logic [PROD_W-1:0] p;
      logic [K_W-1:0]    k;
      sector_type        sector;
   } a_stage_type;

   typedef struct packed {
      logic [LVL_W-1:0] vq;
      logic [XV_W-1:0]  xv;
      logic [LVL_W-1:0] cq;
      logic [XC_W-1:0]  xc;
      logic [K_W-1:0]   k;
      sector_type       sector;
   } b_stage_type;

   typedef struct packed {
      logic [LVL_W-1:0] vq;
      logic [XV_W-1:0]  xv;
      logic [6:0]       ev;
      logic [LVL_W-1:0] cq;
      logic [XC_W-1:0]  xc;
      logic [13:0]      ec;
      logic [K_W-1:0]   k;
      sector_type       sector;
   } c_stage_type;

   logic        a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   a_stage_type a_ff, a_in;
   b_stage_type b_ff, b_in;
   c_stage_type c_ff, c_in;
   front_type   d_ff, d_in;

   logic [HUE_W-1:0]  hue;
   logic [PCT_W-1:0]  sat;
   logic [PCT_W-1:0]  val;
   logic [6:0]        h120;
   logic [6:0]        ramp_dist;
   logic [27:0]       xc_full;
   logic [21:0]       ev_full;
   logic [40:0]       ec_full;
   logic [XV_W-1:0]   v_rem;
   logic [XC_W-1:0]   c_rem;

   always_comb begin
      hue = (in_data.hue_deg > HUE_W'(HUE_MAX)) ? HUE_W'(HUE_MAX) : in_data.hue_deg;
      sat = (in_data.sat_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_data.sat_pct;
      val = (in_data.val_pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : in_data.val_pct;
      priority if (hue < HUE_W'(SEXTANT)) begin
         a_in.sector = SECTOR_RED;
         h120 = 7'(hue);
      end else if (hue < HUE_W'(2 * SEXTANT)) begin
         a_in.sector = SECTOR_YELLOW;
         h120 = 7'(hue);
      end else if (hue < HUE_W'(3 * SEXTANT)) begin
         a_in.sector = SECTOR_GREEN;
         h120 = 7'(hue - HUE_W'(2 * SEXTANT));
      end else if (hue < HUE_W'(4 * SEXTANT)) begin
         a_in.sector = SECTOR_CYAN;
         h120 = 7'(hue - HUE_W'(2 * SEXTANT));
      end else if (hue < HUE_W'(5 * SEXTANT)) begin
         a_in.sector = SECTOR_BLUE;
         h120 = 7'(hue - HUE_W'(4 * SEXTANT));
      end else begin
         a_in.sector = SECTOR_MAGENTA;
         h120 = 7'(hue - HUE_W'(4 * SEXTANT));
      end
      ramp_dist = (h120 >= 7'(SEXTANT)) ? h120 - 7'(SEXTANT) : 7'(SEXTANT) - h120;
      a_in.k = K_W'(7'(SEXTANT) - ramp_dist);
      a_in.v = val;
      a_in.p = PROD_W'(sat) * PROD_W'(val);
   end

   always_comb begin
      xc_full     = 28'(a_ff.p) * 28'(C_REM);
      b_in.vq     = LVL_W'(a_ff.v) * V_QUOT;
      b_in.xv     = XV_W'(a_ff.v) * XV_W'(V_REM);
      b_in.cq     = LVL_W'(a_ff.p) * C_QUOT;
      b_in.xc     = xc_full[XC_W-1:0];
      b_in.k      = a_ff.k;
      b_in.sector = a_ff.sector;
   end

   always_comb begin
      ev_full     = 22'(b_ff.xv) * 22'(V_RECIP);
      ec_full     = 41'(b_ff.xc) * 41'(C_RECIP);
      c_in.vq     = b_ff.vq;
      c_in.xv     = b_ff.xv;
      c_in.ev     = ev_full[V_SHIFT+6:V_SHIFT];
      c_in.cq     = b_ff.cq;
      c_in.xc     = b_ff.xc;
      c_in.ec     = ec_full[C_SHIFT+13:C_SHIFT];
      c_in.k      = b_ff.k;
      c_in.sector = b_ff.sector;
   end

   always_comb begin
      v_rem       = c_ff.xv - XV_W'(c_ff.ev) * XV_W'(PCT_MAX);
      c_rem       = c_ff.xc - XC_W'(c_ff.ec) * XC_W'(PCT_SQ);
      d_in.valid  = c_valid_ff;
      d_in.vf     = c_ff.vq + LVL_W'(c_ff.ev) + LVL_W'(v_rem >= XV_W'(PCT_MAX));
      d_in.c      = c_ff.cq + LVL_W'(c_ff.ec) + LVL_W'(c_rem >= XC_W'(PCT_SQ));
      d_in.k      = c_ff.k;
      d_in.sector = c_ff.sector;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   always_comb begin
      out       = d_ff;
      out.valid = d_valid_ff;
   end

endmodule
